[hw/rtl/ecpa_pkg.sv]
`default_nettype none
package ecpa_pkg;

  localparam int unsigned REG_FIELD_PRIME = 0;
  localparam int unsigned REG_COEFF_A     = 1;
  localparam int unsigned CFG_IDX_BITS    = 1;
  localparam int unsigned PRIME_RESET     = 29;
  localparam int unsigned COEFF_A_RESET   = 13;

  // Sequencer states. Most arithmetic steps run on the single shared bit-serial unit.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_X1,
    ST_RED_Y1,
    ST_RED_X2,
    ST_RED_Y2,
    ST_RED_A,
    ST_CLASSIFY,
    ST_DBL_SQ,
    ST_DBL_NUM,
    ST_DBL_DEN,
    ST_CHD_DEN,
    ST_INV,
    ST_INV_QT,
    ST_INV_FIX,
    ST_SLOPE,
    ST_SLOPE_SQ,
    ST_X3,
    ST_Y3_MUL,
    ST_Y3,
    ST_OUT
  } ecpa_state_e;

  // Operation selector for the shared unit.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL,
    OP_RED,
    OP_DIV
  } ecpa_op_e;

endpackage
`default_nettype wire

[hw/rtl/ecpa_pt_if.sv]
`default_nettype none
interface ecpa_pt_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] px;
  logic [W-1:0] py;
  logic [W-1:0] qx;
  logic [W-1:0] qy;

  modport source (output valid, px, py, qx, qy, input ready);
  modport sink (input valid, px, py, qx, qy, output ready);
endinterface
`default_nettype wire

[hw/rtl/ecpa_sum_if.sv]
`default_nettype none
interface ecpa_sum_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] sum_x;
  logic [W-1:0] sum_y;
  logic [W-1:0] slope;
  logic         at_infinity;

  modport source (output valid, sum_x, sum_y, slope, at_infinity, input ready);
  modport sink (input valid, sum_x, sum_y, slope, at_infinity, output ready);
endinterface
`default_nettype wire

[hw/rtl/ecpa_serial_unit.sv]
`default_nettype none
// Bit-serial modular multiplier, reducer and divider, one bit per cycle.
//   OP_MUL: res = a*b mod m   (interleaved shift-add, MSB of b first)
//   OP_RED: res = a mod m     (restoring reduction, MSB of a first)
//   OP_DIV: quo = a / b, res = a mod b (restoring division, b != 0)
module ecpa_serial_unit
  import ecpa_pkg::*;
#(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire ecpa_op_e     op_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic [W-1:0] m_i,
  output logic              done_o,
  output logic [W-1:0]      res_o,
  output logic [W-1:0]      quo_o
);

  localparam int unsigned CW = $clog2(W + 1);

  ecpa_op_e      op_q, op_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [W-1:0]  acc_q, acc_d;   // partial remainder / product
  logic [W-1:0]  sh_q, sh_d;     // bits shifted in, MSB first; becomes quotient
  logic [W-1:0]  opb_q, opb_d;   // addend for multiply
  logic [W-1:0]  mod_q, mod_d;   // modulus or divisor
  logic          done_q, done_d;

  logic [W:0] dbl;
  logic [W:0] dbl_red;
  logic [W:0] add;
  logic [W:0] add_red;
  logic       bit_in;

  always_comb begin
    bit_in  = sh_q[W-1];
    dbl     = {acc_q, 1'b0};
    if (op_q != OP_MUL) begin
      dbl = {acc_q, bit_in};
    end
    dbl_red = (dbl >= {1'b0, mod_q}) ? dbl - {1'b0, mod_q} : dbl;
    add     = dbl_red + {1'b0, opb_q};
    add_red = (add >= {1'b0, mod_q}) ? add - {1'b0, mod_q} : add;
  end

  always_comb begin
    op_d   = op_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    opb_d  = opb_q;
    mod_d  = mod_q;
    done_d = 1'b0;
    if (start_i) begin
      op_d   = op_i;
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      acc_d  = '0;
      mod_d  = (op_i == OP_DIV) ? b_i : m_i;
      opb_d  = a_i;
      sh_d   = (op_i == OP_MUL) ? b_i : a_i;
    end else if (busy_q) begin
      if (op_q == OP_MUL) begin
        acc_d = bit_in ? add_red[W-1:0] : dbl_red[W-1:0];
        sh_d  = {sh_q[W-2:0], 1'b0};
      end else begin
        acc_d = dbl_red[W-1:0];
        sh_d  = {sh_q[W-2:0], (dbl >= {1'b0, mod_q})};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_NONE;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    opb_q <= opb_d;
    mod_q <= mod_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;
  assign quo_o  = sh_q;

endmodule
`default_nettype wire

[hw/rtl/ec_point_add_prime_field_unit.sv]
`default_nettype none
// Affine point adder on y^2 = x^3 + a*x + b over GF(p), p and a set through
// a write port (index 0: prime, index 1: coefficient a; reset 29 and 13).
// Input channel pt carries px, py, qx, qy; output channel sum carries sum_x,
// sum_y, slope and at_infinity. One word in gives exactly one word out.
// Items are processed one at a time by a sequencer that drives one
// bit-serial unit (multiply or reduce mod p, or divide). Chord addition
// runs 9 unit operations and doubling 11, plus a division and a
// multiplication per inversion step (at most about 1.5*FIELD_BITS steps).
// Zero or one as modulus skips all arithmetic; a point plus its negative
// stops after the operand reductions; both give at_infinity with zero
// coordinates.
// Reset returns the sequencer to idle and loads the register defaults.
// The result word is held in an output register until taken; a stalled
// receiver holds the block, which takes the next word once the result
// has left.
module ec_point_add_prime_field_unit
  import ecpa_pkg::*;
#(
  parameter int unsigned FIELD_BITS = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [FIELD_BITS-1:0]   cfg_data_i,
  ecpa_pt_if.sink                      pt,
  ecpa_sum_if.source                   sum
);

  localparam int unsigned W = FIELD_BITS;

  logic [W-1:0] prime_q, coeff_q;
  ecpa_state_e  st_q, st_d;
  logic [W-1:0] x1_q, y1_q, x2_q, y2_q, ca_q;
  logic [W-1:0] s_q, t_q, u_q;
  // Euclid registers: remainders and signed cofactors (kept mod p)
  logic [W-1:0] r1_q, r2_q, t1_q, t2_q, q_q;
  logic [W-1:0] ox_q, oy_q, os_q;
  logic         oinf_q, ovalid_q;
  logic         dbl_q;

  logic         u_start;
  ecpa_op_e     u_op;
  logic [W-1:0] u_a, u_b;
  logic         u_done;
  logic [W-1:0] u_res, u_quo;
  logic         issued_q;

  ecpa_serial_unit #(.W(W)) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(u_start),
    .op_i   (u_op),
    .a_i    (u_a),
    .b_i    (u_b),
    .m_i    (prime_q),
    .done_o (u_done),
    .res_o  (u_res),
    .quo_o  (u_quo)
  );

  function automatic logic [W-1:0] msub(logic [W-1:0] a, logic [W-1:0] b,
                                        logic [W-1:0] m);
    logic [W:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      d = d + {1'b0, m};
    end
    return d[W-1:0];
  endfunction

  function automatic logic [W-1:0] madd(logic [W-1:0] a, logic [W-1:0] b,
                                        logic [W-1:0] m);
    logic [W:0] d;
    d = {1'b0, a} + {1'b0, b};
    if (d >= {1'b0, m}) begin
      d = d - {1'b0, m};
    end
    return d[W-1:0];
  endfunction

  logic tiny_mod;
  logic in_acc;
  logic out_acc;
  logic step_op;

  assign tiny_mod = (prime_q < W'(2));
  assign in_acc   = pt.valid && pt.ready;
  assign out_acc  = sum.valid && sum.ready;
  assign pt.ready = (st_q == ST_IDLE) && !ovalid_q;

  // States that run one unit operation.
  always_comb begin
    step_op = 1'b1;
    unique case (st_q)
      ST_IDLE, ST_CLASSIFY, ST_INV_FIX, ST_X3, ST_Y3, ST_OUT: step_op = 1'b0;
      ST_INV:  step_op = (r2_q != '0);
      default: step_op = 1'b1;
    endcase
  end

  // Unit operands.
  always_comb begin
    u_op = OP_MUL;
    u_a  = '0;
    u_b  = '0;
    unique case (st_q)
      ST_RED_X1:   begin u_op = OP_RED; u_a = x1_q; end
      ST_RED_Y1:   begin u_op = OP_RED; u_a = y1_q; end
      ST_RED_X2:   begin u_op = OP_RED; u_a = x2_q; end
      ST_RED_Y2:   begin u_op = OP_RED; u_a = y2_q; end
      ST_RED_A:    begin u_op = OP_RED; u_a = coeff_q; end
      ST_DBL_SQ:   begin u_a = x1_q; u_b = x1_q; end
      ST_DBL_NUM:  begin u_a = t_q; u_b = W'(3); end
      ST_DBL_DEN:  begin u_a = y1_q; u_b = W'(2); end
      ST_CHD_DEN:  begin u_op = OP_RED; u_a = msub(x2_q, x1_q, prime_q); end
      ST_INV:      begin u_op = OP_DIV; u_a = r1_q; u_b = r2_q; end
      ST_INV_QT:   begin u_a = t2_q; u_b = q_q; end
      ST_SLOPE:    begin u_a = t_q; u_b = u_q; end
      ST_SLOPE_SQ: begin u_a = s_q; u_b = s_q; end
      ST_Y3_MUL:   begin u_a = s_q; u_b = msub(x1_q, ox_q, prime_q); end
      default:     begin u_op = OP_NONE; end
    endcase
  end

  assign u_start = step_op && !issued_q;

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:     if (in_acc) st_d = tiny_mod ? ST_OUT : ST_RED_X1;
      ST_RED_X1:   if (u_done) st_d = ST_RED_Y1;
      ST_RED_Y1:   if (u_done) st_d = ST_RED_X2;
      ST_RED_X2:   if (u_done) st_d = ST_RED_Y2;
      ST_RED_Y2:   if (u_done) st_d = ST_RED_A;
      ST_RED_A:    if (u_done) st_d = ST_CLASSIFY;
      ST_CLASSIFY: begin
        if (x1_q != x2_q) begin
          st_d = ST_CHD_DEN;
        end else if (madd(y1_q, y2_q, prime_q) == '0) begin
          st_d = ST_OUT;
        end else begin
          st_d = ST_DBL_SQ;
        end
      end
      ST_DBL_SQ:   if (u_done) st_d = ST_DBL_NUM;
      ST_DBL_NUM:  if (u_done) st_d = ST_DBL_DEN;
      ST_DBL_DEN:  if (u_done) st_d = ST_INV;
      ST_CHD_DEN:  if (u_done) st_d = ST_INV;
      ST_INV: begin
        if (r2_q == '0) begin
          st_d = ST_INV_FIX;
        end else if (u_done) begin
          st_d = ST_INV_QT;
        end
      end
      ST_INV_QT:   if (u_done) st_d = ST_INV;
      ST_INV_FIX:  st_d = ST_SLOPE;
      ST_SLOPE:    if (u_done) st_d = ST_SLOPE_SQ;
      ST_SLOPE_SQ: if (u_done) st_d = ST_X3;
      ST_X3:       st_d = ST_Y3_MUL;
      ST_Y3_MUL:   if (u_done) st_d = ST_Y3;
      ST_Y3:       st_d = ST_OUT;
      ST_OUT:      st_d = ST_IDLE;
      default:     st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      prime_q  <= W'(PRIME_RESET);
      coeff_q  <= W'(COEFF_A_RESET);
      ovalid_q <= 1'b0;
      issued_q <= 1'b0;
      oinf_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (int'(cfg_idx_i))
          REG_FIELD_PRIME: prime_q <= cfg_data_i;
          REG_COEFF_A:     coeff_q <= cfg_data_i;
          default:         ;
        endcase
      end
      // one unit operation per step; re-arm when it finishes
      if (u_done) begin
        issued_q <= 1'b0;
      end else if (u_start) begin
        issued_q <= 1'b1;
      end
      if (out_acc) begin
        ovalid_q <= 1'b0;
      end
      if (st_q == ST_IDLE && in_acc) begin
        oinf_q <= 1'b1;
      end
      if (st_q == ST_CHD_DEN || st_q == ST_DBL_DEN) begin
        oinf_q <= 1'b0;
      end
      if (st_q == ST_OUT) begin
        ovalid_q <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          x1_q <= pt.px;
          y1_q <= pt.py;
          x2_q <= pt.qx;
          y2_q <= pt.qy;
          ox_q <= '0;
          oy_q <= '0;
          os_q <= '0;
        end
      end
      ST_RED_X1:   if (u_done) x1_q <= u_res;
      ST_RED_Y1:   if (u_done) y1_q <= u_res;
      ST_RED_X2:   if (u_done) x2_q <= u_res;
      ST_RED_Y2:   if (u_done) y2_q <= u_res;
      ST_RED_A:    if (u_done) ca_q <= u_res;
      ST_CLASSIFY: begin
        dbl_q <= (x1_q == x2_q);
        t_q   <= msub(y2_q, y1_q, prime_q);
      end
      ST_DBL_SQ:   if (u_done) t_q <= u_res;
      ST_DBL_NUM:  if (u_done) t_q <= madd(u_res, ca_q, prime_q);
      ST_DBL_DEN, ST_CHD_DEN: begin
        if (u_done) begin
          r1_q <= prime_q;
          r2_q <= u_res;
          t1_q <= '0;
          t2_q <= W'(1);
        end
      end
      ST_INV: begin
        // hold the quotient for the cofactor update
        if (u_done) begin
          r1_q <= r2_q;
          r2_q <= u_res;
          q_q  <= u_quo;
        end
      end
      ST_INV_QT: begin
        // cofactors tracked mod p, which equals the signed result mod p
        if (u_done) begin
          t1_q <= t2_q;
          t2_q <= msub(t1_q, u_res, prime_q);
        end
      end
      ST_SLOPE:    if (u_done) s_q <= u_res;
      ST_SLOPE_SQ: if (u_done) u_q <= u_res;
      ST_X3: begin
        if (dbl_q) begin
          ox_q <= msub(u_q, madd(x1_q, x1_q, prime_q), prime_q);
        end else begin
          ox_q <= msub(msub(u_q, x1_q, prime_q), x2_q, prime_q);
        end
      end
      ST_Y3_MUL:   if (u_done) u_q <= u_res;
      ST_Y3: begin
        oy_q <= msub(u_q, y1_q, prime_q);
        os_q <= s_q;
      end
      ST_INV_FIX:  u_q <= t1_q;
      default: ;
    endcase
  end

  assign sum.valid       = ovalid_q;
  assign sum.sum_x       = ox_q;
  assign sum.sum_y       = oy_q;
  assign sum.slope       = os_q;
  assign sum.at_infinity = oinf_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt.ready |-> (st_q == ST_IDLE)) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !sum.ready) |=> ovalid_q) else $error("result dropped");
  a_inf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oinf_q) |-> (ox_q == '0 && oy_q == '0 && os_q == '0))
    else $error("nonzero coordinates at infinity");

endmodule
`default_nettype wire
